// ===== rtl/mac_pkg.sv =====
`default_nettype none

package mac_pkg;

    localparam int WordWidth = 32;
    localparam int LongWidth = 64;
    localparam int CycWidth  = 3;

    typedef enum logic [2:0] {
        ACT_MUL   = 3'd0,
        ACT_MLA   = 3'd1,
        ACT_UMULL = 3'd2,
        ACT_UMLAL = 3'd3,
        ACT_SMULL = 3'd4,
        ACT_SMLAL = 3'd5
    } action_t;

    // carried from the multiply stage to the accumulate stage
    typedef struct packed {
        logic [LongWidth-1:0] product;
        logic [LongWidth-1:0] addend;
        logic                 long_form;
        logic                 set_flags;
        logic [CycWidth-1:0]  cycles;
    } prod_t;

endpackage

`default_nettype wire

// ===== rtl/multiply_accumulate_unit.sv =====
`default_nettype none

// Multiply-accumulate unit: 32-bit multiply and multiply-accumulate, and unsigned
// or signed 32x32->64 long multiply with optional 64-bit accumulate. Takes one
// item per cycle while the output is not stalled; an item is registered in the
// first stage and its result in the second. The first stage holds the 33x33
// signed multiplier, the second the 64-bit accumulate add with the N/Z flag logic.
// The flags are zero unless set_flags is given; multiplier_cycles reports the 1..4
// early termination count taken from the multiplier's upper bytes.
module multiply_accumulate_unit
    import mac_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // multiplicand, multiplier, addend_lo, addend_hi
    input  wire logic [127:0] s_tdata,
    // action, set_flags
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_lo, result_hi, flag_negative, flag_zero, flags_written,
    // multiplier_cycles, zero padding
    output logic [71:0]       m_tdata
);

    logic                 prod_valid;
    logic                 prod_ready;
    prod_t                prod;
    logic                 out_valid_reg;
    logic [71:0]          out_data_reg;
    logic [71:0]          out_data_next;
    logic [LongWidth-1:0] sum;
    logic                 neg;
    logic                 zero;

    mac_mul_stage u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .action       (s_tuser[2:0]),
        .set_flags    (s_tuser[3]),
        .multiplicand (s_tdata[31:0]),
        .multiplier   (s_tdata[63:32]),
        .addend_lo    (s_tdata[95:64]),
        .addend_hi    (s_tdata[127:96]),
        .out_valid    (prod_valid),
        .out_ready    (prod_ready),
        .out_data     (prod)
    );

    assign sum = prod.product + prod.addend;

    always_comb
    begin
        if (prod.long_form)
        begin
            neg  = sum[LongWidth-1];
            zero = (sum == '0);
        end
        else
        begin
            neg  = sum[WordWidth-1];
            zero = (sum[WordWidth-1:0] == '0);
        end
        out_data_next[31:0]  = sum[WordWidth-1:0];
        out_data_next[63:32] = prod.long_form ? sum[LongWidth-1:WordWidth] : '0;
        out_data_next[64]    = prod.set_flags & neg;
        out_data_next[65]    = prod.set_flags & zero;
        out_data_next[66]    = prod.set_flags;
        out_data_next[69:67] = prod.cycles;
        out_data_next[71:70] = 2'b00;
    end

    assign prod_ready = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (prod_ready)
            out_valid_reg <= prod_valid;
    end

    always_ff @(posedge clk)
    begin
        if (prod_ready && prod_valid)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mac_mul_stage.sv =====
`default_nettype none

module mac_mul_stage
    import mac_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2:0]           action,
    input  wire logic                 set_flags,
    input  wire logic [WordWidth-1:0] multiplicand,
    input  wire logic [WordWidth-1:0] multiplier,
    input  wire logic [WordWidth-1:0] addend_lo,
    input  wire logic [WordWidth-1:0] addend_hi,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output prod_t                     out_data
);

    logic                        valid_reg;
    prod_t                       data_reg;
    prod_t                       data_next;
    logic                        is_long;
    logic                        is_signed;
    logic                        accumulate;
    logic                        check_ones;
    logic signed [WordWidth:0]   op_a;
    logic signed [WordWidth:0]   op_b;
    logic signed [2*WordWidth+1:0] full_product;
    logic [CycWidth-1:0]         cycles;

    always_comb
    begin
        case (action)
            ACT_MUL:   begin is_long = 1'b0; is_signed = 1'b0; accumulate = 1'b0; end
            ACT_MLA:   begin is_long = 1'b0; is_signed = 1'b0; accumulate = 1'b1; end
            ACT_UMULL: begin is_long = 1'b1; is_signed = 1'b0; accumulate = 1'b0; end
            ACT_UMLAL: begin is_long = 1'b1; is_signed = 1'b0; accumulate = 1'b1; end
            ACT_SMULL: begin is_long = 1'b1; is_signed = 1'b1; accumulate = 1'b0; end
            ACT_SMLAL: begin is_long = 1'b1; is_signed = 1'b1; accumulate = 1'b1; end
            // spare codes behave as the 32-bit forms
            default:   begin is_long = 1'b0; is_signed = 1'b0; accumulate = action[0]; end
        endcase
    end

    // early termination looks for sign extension, except for unsigned long forms
    assign check_ones = !(is_long && !is_signed);

    always_comb
    begin
        if (multiplier[31:8] == 24'd0 || (check_ones && multiplier[31:8] == 24'hFFFFFF))
            cycles = 3'd1;
        else if (multiplier[31:16] == 16'd0
                 || (check_ones && multiplier[31:16] == 16'hFFFF))
            cycles = 3'd2;
        else if (multiplier[31:24] == 8'd0 || (check_ones && multiplier[31:24] == 8'hFF))
            cycles = 3'd3;
        else
            cycles = 3'd4;
    end

    assign op_a         = signed'({is_signed & multiplicand[WordWidth-1], multiplicand});
    assign op_b         = signed'({is_signed & multiplier[WordWidth-1], multiplier});
    assign full_product = op_a * op_b;

    always_comb
    begin
        data_next.product   = full_product[LongWidth-1:0];
        data_next.long_form = is_long;
        data_next.set_flags = set_flags;
        data_next.cycles    = cycles;
        if (!accumulate)
            data_next.addend = '0;
        else if (is_long)
            data_next.addend = {addend_hi, addend_lo};
        else
            data_next.addend = {{WordWidth{1'b0}}, addend_lo};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== rtl/mac_checker.sv =====
`default_nettype none

module mac_assertions (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[69:67] != 3'd0 && m_tdata[69:67] <= 3'd4)
        else $error("cycle count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[66] |-> m_tdata[65:64] == 2'b00)
        else $error("flags set without request");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65] |-> m_tdata[31:0] == 32'd0 && !m_tdata[64])
        else $error("zero flag with nonzero result");

endmodule

bind multiply_accumulate_unit mac_assertions u_mac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
